### design/pbcs_pkg.sv
`default_nettype none

package pbcs_pkg;

    // Field widths
    localparam int MODE_W     = 3;
    localparam int KEY_W      = 5;
    localparam int DIGIT_W    = 4;
    localparam int DCNT_W     = 2;
    localparam int TARGET_W   = 7;
    localparam int TOTAL_W    = 16;
    localparam int BOXES_W    = 8;
    localparam int DEBOUNCE_W = 16;
    localparam int PILLS_W    = 8;

    // Defaults
    localparam int PILL_COUNT_WIDTH_DEF = 8;
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd250;

    // Operating modes
    localparam logic [MODE_W-1:0] MODE_OFF   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_STOP  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ENTRY = 3'd2;
    localparam logic [MODE_W-1:0] MODE_MOVE  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_COUNT = 3'd4;

    // Keypad codes
    localparam logic [KEY_W-1:0] KEY_DIGIT_MAX = 5'd9;
    localparam logic [KEY_W-1:0] KEY_A         = 5'd10;
    localparam logic [KEY_W-1:0] KEY_STAR      = 5'd14;
    localparam logic [KEY_W-1:0] KEY_HASH      = 5'd15;

    // Largest two-digit target
    localparam logic [TARGET_W-1:0] TARGET_MAX = 7'd99;

    // Register map
    localparam int PADDR_W = 3;
    localparam logic [PADDR_W-1:0] ADDR_DEBOUNCE = 3'd0;

    // Sequencer state, pill counter excluded (its width is a parameter)
    typedef struct packed {
        logic [MODE_W-1:0]     mode;
        logic [DCNT_W-1:0]     digits;
        logic [DIGIT_W-1:0]    tens;
        logic [DIGIT_W-1:0]    ones;
        logic [TARGET_W-1:0]   target;
        logic [TOTAL_W-1:0]    total;
        logic [BOXES_W-1:0]    boxes;
        logic [DEBOUNCE_W-1:0] debounce;
    } pbcs_ctrl_t;

endpackage

`default_nettype wire

### design/pbcs_next.sv
`default_nettype none

module pbcs_next #(
    parameter int PILL_COUNT_WIDTH = pbcs_pkg::PILL_COUNT_WIDTH_DEF
) (
    input  wire pbcs_pkg::pbcs_ctrl_t        cur,
    input  wire logic [PILL_COUNT_WIDTH-1:0] cur_pills,
    input  wire logic [pbcs_pkg::KEY_W-1:0]  key_code,
    input  wire logic                        box_sensor,
    input  wire logic                        pill_pulse,
    input  wire logic [pbcs_pkg::DEBOUNCE_W-1:0] debounce_ticks,
    output pbcs_pkg::pbcs_ctrl_t             nxt,
    output logic [PILL_COUNT_WIDTH-1:0]      nxt_pills
);
    import pbcs_pkg::*;

    logic                        is_star;
    logic                        is_hash;
    logic                        is_digit;
    logic [DIGIT_W-1:0]          tens_new;
    logic [DIGIT_W-1:0]          ones_new;
    logic [TARGET_W-1:0]         target_new;
    logic [DEBOUNCE_W-1:0]       deb_inc;
    logic [PILL_COUNT_WIDTH-1:0] pills_inc;
    logic                        box_full;

    assign is_star  = (key_code == KEY_STAR);
    assign is_hash  = (key_code == KEY_HASH);
    assign is_digit = (key_code <= KEY_DIGIT_MAX);

    // Digit capture: tens first, then ones
    assign tens_new = (is_digit && cur.digits == 2'd0) ? key_code[DIGIT_W-1:0] : cur.tens;
    assign ones_new = (is_digit && cur.digits == 2'd1) ? key_code[DIGIT_W-1:0] : cur.ones;
    assign target_new = 7'({3'd0, tens_new} * 7'd10 + {3'd0, ones_new});

    // Saturating debounce count
    assign deb_inc = (cur.debounce == '1) ? cur.debounce : cur.debounce + 16'd1;

    // Pill count after this tick's pulse
    assign pills_inc = pill_pulse ? cur_pills + PILL_COUNT_WIDTH'(1) : cur_pills;
    assign box_full  = (TOTAL_W'(pills_inc) >= TOTAL_W'(cur.target));

    always_comb
    begin
        nxt       = cur;
        nxt_pills = cur_pills;
        unique case (cur.mode)
            MODE_STOP:
            begin
                nxt_pills = '0;
                if (is_star)
                begin
                    nxt.digits = '0;
                    nxt.mode   = MODE_ENTRY;
                end
                else if (is_hash)
                begin
                    nxt.digits = '0;
                    nxt.mode   = MODE_OFF;
                end
            end
            MODE_ENTRY:
            begin
                if (is_digit)
                begin
                    if (cur.digits < 2'd2)
                    begin
                        nxt.tens   = tens_new;
                        nxt.ones   = ones_new;
                        nxt.target = target_new;
                        nxt.digits = cur.digits + 2'd1;
                    end
                    else
                    begin
                        nxt.digits = '0;
                    end
                end
                else if (is_star)
                begin
                    nxt.target   = target_new;
                    nxt_pills    = '0;
                    nxt.debounce = '0;
                    nxt.mode     = MODE_MOVE;
                end
                else if (is_hash)
                begin
                    nxt.target = target_new;
                    nxt.mode   = MODE_STOP;
                end
            end
            MODE_MOVE:
            begin
                nxt_pills = '0;
                if (is_star || is_hash)
                begin
                    nxt.target   = '0;
                    nxt.digits   = '0;
                    nxt.debounce = '0;
                    nxt.mode     = is_hash ? MODE_STOP : MODE_ENTRY;
                end
                else if (box_sensor)
                begin
                    if (deb_inc >= debounce_ticks)
                    begin
                        nxt.debounce = '0;
                        nxt.mode     = MODE_COUNT;
                    end
                    else
                    begin
                        nxt.debounce = deb_inc;
                    end
                end
                else
                begin
                    nxt.debounce = '0;
                end
            end
            MODE_COUNT:
            begin
                nxt_pills = pills_inc;
                if (box_full)
                begin
                    nxt.boxes    = cur.boxes + 8'd1;
                    nxt.total    = cur.total + TOTAL_W'(pills_inc);
                    nxt_pills    = '0;
                    nxt.debounce = '0;
                    nxt.mode     = MODE_MOVE;
                end
                else if (is_star || is_hash)
                begin
                    nxt_pills  = '0;
                    nxt.target = '0;
                    nxt.boxes  = '0;
                    nxt.digits = '0;
                    nxt.mode   = is_hash ? MODE_STOP : MODE_ENTRY;
                end
            end
            default:
            begin
                // Off, and any unused mode code
                nxt.mode = (key_code == KEY_A) ? MODE_STOP : MODE_OFF;
            end
        endcase
    end

endmodule

`default_nettype wire

### design/pill_batch_counter_sequencer_unit.sv
// Pill batch counter sequencer.
// Input channel (in_valid/in_ready) carries one tick: key_code, box_sensor
// and pill_pulse. Output channel (out_valid/out_ready) returns one result per
// tick: mode, belt and motor drives, pill count, target, total and boxes,
// all showing the state after that tick.
// out_valid rises once an accepted tick has passed from the input register
// through the state update into the result register; a stall can hold it.
// Throughput: one tick per cycle while out_ready stays high; the state update
// is a single pass of compares and increments between input and result register.
// A stalled receiver holds the result register; the input register still
// takes one more transaction, then in_ready drops until out_ready returns.
// Reset (rst_n low, asynchronous) puts the sequencer in the off mode with
// all counts cleared and debounce_ticks at 250; no transaction is pending.
// APB port: debounce_ticks at byte address 0, written on the access cycle;
// write it only while no tick is in flight.
`default_nettype none

module pill_batch_counter_sequencer_unit #(
    parameter int PILL_COUNT_WIDTH = pbcs_pkg::PILL_COUNT_WIDTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // APB configuration
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [pbcs_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [31:0]                     pwdata,
    output logic      [31:0]                     prdata,
    output logic                                 pready,
    // Tick input
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [pbcs_pkg::KEY_W-1:0]      key_code,
    input  wire logic                            box_sensor,
    input  wire logic                            pill_pulse,
    // Result output
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [pbcs_pkg::MODE_W-1:0]          out_mode,
    output logic                                 belt_on,
    output logic                                 motor_on,
    output logic [pbcs_pkg::PILLS_W-1:0]         out_pills,
    output logic [pbcs_pkg::TARGET_W-1:0]        out_target,
    output logic [pbcs_pkg::TOTAL_W-1:0]         out_total,
    output logic [pbcs_pkg::BOXES_W-1:0]         out_boxes
);
    import pbcs_pkg::*;

    logic [DEBOUNCE_W-1:0]       debounce_ticks_reg;
    logic                        cfg_wr;

    logic                        in_vld_reg;
    logic [KEY_W-1:0]            key_reg;
    logic                        sensor_reg;
    logic                        pulse_reg;

    pbcs_ctrl_t                  ctrl_reg;
    pbcs_ctrl_t                  ctrl_next;
    logic [PILL_COUNT_WIDTH-1:0] pills_reg;
    logic [PILL_COUNT_WIDTH-1:0] pills_next;

    logic                        out_vld_reg;
    logic [MODE_W-1:0]           mode_out_reg;
    logic                        belt_reg;
    logic                        motor_reg;
    logic [PILLS_W-1:0]          pills_out_reg;
    logic [TARGET_W-1:0]         target_out_reg;
    logic [TOTAL_W-1:0]          total_out_reg;
    logic [BOXES_W-1:0]          boxes_out_reg;

    logic                        advance;

    // Configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_DEBOUNCE);
    assign prdata = (paddr == ADDR_DEBOUNCE) ? {16'd0, debounce_ticks_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            debounce_ticks_reg <= DEBOUNCE_RESET;
        else if (cfg_wr)
            debounce_ticks_reg <= pwdata[DEBOUNCE_W-1:0];
    end

    // Pipeline flow control
    assign advance  = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (in_ready)
            in_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            key_reg    <= key_code;
            sensor_reg <= box_sensor;
            pulse_reg  <= pill_pulse;
        end
    end

    // Sequencer next state
    pbcs_next #(
        .PILL_COUNT_WIDTH (PILL_COUNT_WIDTH)
    ) u_next (
        .cur            (ctrl_reg),
        .cur_pills      (pills_reg),
        .key_code       (key_reg),
        .box_sensor     (sensor_reg),
        .pill_pulse     (pulse_reg),
        .debounce_ticks (debounce_ticks_reg),
        .nxt            (ctrl_next),
        .nxt_pills      (pills_next)
    );

    // Sequencer state; the all-zero state is the off mode with counts cleared
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg  <= '0;
            pills_reg <= '0;
        end
        else if (advance)
        begin
            ctrl_reg  <= ctrl_next;
            pills_reg <= pills_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (advance)
            out_vld_reg <= 1'b1;
        else if (out_ready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mode_out_reg   <= ctrl_next.mode;
            belt_reg       <= (ctrl_next.mode == MODE_MOVE);
            motor_reg      <= (ctrl_next.mode == MODE_COUNT);
            pills_out_reg  <= PILLS_W'(pills_next);
            target_out_reg <= ctrl_next.target;
            total_out_reg  <= ctrl_next.total;
            boxes_out_reg  <= ctrl_next.boxes;
        end
    end

    assign out_valid  = out_vld_reg;
    assign out_mode   = mode_out_reg;
    assign belt_on    = belt_reg;
    assign motor_on   = motor_reg;
    assign out_pills  = pills_out_reg;
    assign out_target = target_out_reg;
    assign out_total  = total_out_reg;
    assign out_boxes  = boxes_out_reg;

endmodule

`default_nettype wire

### design/pbcs_checker.sv
`default_nettype none

module pbcs_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             out_valid,
    input wire logic                             out_ready,
    input wire logic [pbcs_pkg::MODE_W-1:0]      out_mode,
    input wire logic                             belt_on,
    input wire logic                             motor_on,
    input wire logic [pbcs_pkg::TARGET_W-1:0]    out_target
);
    import pbcs_pkg::*;

    // Belt drive follows the moving mode
    a_belt_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (belt_on == (out_mode == MODE_MOVE)))
        else $error("belt_on disagrees with out_mode");

    // Motor drive follows the counting mode
    a_motor_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (motor_on == (out_mode == MODE_COUNT)))
        else $error("motor_on disagrees with out_mode");

    // Belt and motor never run together
    a_drive_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(belt_on && motor_on))
        else $error("belt and motor both on");

    // Reported mode is always one of the five modes
    a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_mode <= MODE_COUNT))
        else $error("out_mode out of range");

    // A stalled result stays presented
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_target) && $stable(out_mode))
        else $error("stalled result changed");

endmodule

bind pill_batch_counter_sequencer_unit pbcs_checker u_pbcs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_mode   (out_mode),
    .belt_on    (belt_on),
    .motor_on   (motor_on),
    .out_target (out_target)
);

`default_nettype wire

### bench/sequencer_check.sv
`timescale 1ns / 1ps

module sequencer_check (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // APB configuration
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [pbcs_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [31:0]                     pwdata,
    input  wire logic [31:0]                     prdata,
    input  wire logic                            pready,
    // Tick channel
    input  wire logic                            in_valid,
    input  wire logic                            in_ready,
    input  wire logic [pbcs_pkg::KEY_W-1:0]      key_code,
    input  wire logic                            box_sensor,
    input  wire logic                            pill_pulse,
    // Result channel
    input  wire logic                            out_valid,
    input  wire logic                            out_ready,
    input  wire logic [pbcs_pkg::MODE_W-1:0]     out_mode,
    input  wire logic                            belt_on,
    input  wire logic                            motor_on,
    input  wire logic [pbcs_pkg::PILLS_W-1:0]    out_pills,
    input  wire logic [pbcs_pkg::TARGET_W-1:0]   out_target,
    input  wire logic [pbcs_pkg::TOTAL_W-1:0]    out_total,
    input  wire logic [pbcs_pkg::BOXES_W-1:0]    out_boxes,
    // Status for the stimulus side
    output int                                   mismatches,
    output int                                   outstanding
);
    import pbcs_pkg::*;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic                belt;
        logic                motor;
        logic [PILLS_W-1:0]  pills;
        logic [TARGET_W-1:0] target;
        logic [TOTAL_W-1:0]  total;
        logic [BOXES_W-1:0]  boxes;
    } tick_status_t;

    // Shadow copy of the sequencer registers
    logic [DEBOUNCE_W-1:0] cfg_debounce;
    logic [MODE_W-1:0]     st_mode;
    logic [DCNT_W-1:0]     st_digits;
    logic [DIGIT_W-1:0]    st_tens;
    logic [DIGIT_W-1:0]    st_ones;
    logic [TARGET_W-1:0]   st_target;
    logic [PILLS_W-1:0]    st_pills;
    logic [TOTAL_W-1:0]    st_total;
    logic [BOXES_W-1:0]    st_boxes;
    logic [DEBOUNCE_W-1:0] st_debounce;

    tick_status_t expected_status [$];
    int           error_total = 0;

    // Target from the two keypad digits
    function automatic logic [TARGET_W-1:0] entered_target(input logic [DIGIT_W-1:0] tens,
                                                           input logic [DIGIT_W-1:0] ones);
        int value;
        value = tens * 10 + ones;
        return value[TARGET_W-1:0];
    endfunction

    // One tick of the bottling sequence; returns the status after the tick
    task automatic advance_sequencer(input logic [KEY_W-1:0] key, input logic sensor,
                                     input logic pulse, output tick_status_t status);
        logic star;
        logic hash;
        star = (key == KEY_STAR);
        hash = (key == KEY_HASH);
        case (st_mode)
            MODE_STOP:
            begin
                st_pills = '0;
                if (star)
                begin
                    st_digits = '0;
                    st_mode   = MODE_ENTRY;
                end
                else if (hash)
                begin
                    st_digits = '0;
                    st_mode   = MODE_OFF;
                end
            end
            MODE_ENTRY:
            begin
                if (key <= KEY_DIGIT_MAX)
                begin
                    // a third digit only restarts entry and is dropped
                    if (st_digits < 2)
                    begin
                        if (st_digits == 0)
                            st_tens = key[DIGIT_W-1:0];
                        else
                            st_ones = key[DIGIT_W-1:0];
                        st_target = entered_target(st_tens, st_ones);
                        st_digits = st_digits + 1'b1;
                    end
                    else
                        st_digits = '0;
                end
                else if (star)
                begin
                    st_target   = entered_target(st_tens, st_ones);
                    st_pills    = '0;
                    st_debounce = '0;
                    st_mode     = MODE_MOVE;
                end
                else if (hash)
                begin
                    st_target = entered_target(st_tens, st_ones);
                    st_mode   = MODE_STOP;
                end
            end
            MODE_MOVE:
            begin
                st_pills = '0;
                if (star || hash)
                begin
                    st_target   = '0;
                    st_digits   = '0;
                    st_debounce = '0;
                    st_mode     = hash ? MODE_STOP : MODE_ENTRY;
                end
                else if (sensor)
                begin
                    // saturating debounce counter
                    if (st_debounce != '1)
                        st_debounce = st_debounce + 1'b1;
                    if (st_debounce >= cfg_debounce)
                    begin
                        st_debounce = '0;
                        st_mode     = MODE_COUNT;
                    end
                end
                else
                    st_debounce = '0;
            end
            MODE_COUNT:
            begin
                if (pulse)
                    st_pills = st_pills + 1'b1;
                // box complete wins over an abort key
                if (st_pills >= st_target)
                begin
                    st_boxes    = st_boxes + 1'b1;
                    st_total    = st_total + st_pills;
                    st_pills    = '0;
                    st_debounce = '0;
                    st_mode     = MODE_MOVE;
                end
                else if (star || hash)
                begin
                    st_pills  = '0;
                    st_target = '0;
                    st_boxes  = '0;
                    st_digits = '0;
                    st_mode   = hash ? MODE_STOP : MODE_ENTRY;
                end
            end
            default:
            begin
                st_mode = (key == KEY_A) ? MODE_STOP : MODE_OFF;
            end
        endcase
        status.mode   = st_mode;
        status.belt   = (st_mode == MODE_MOVE);
        status.motor  = (st_mode == MODE_COUNT);
        status.pills  = st_pills;
        status.target = st_target;
        status.total  = st_total;
        status.boxes  = st_boxes;
    endtask

    // Field-by-field comparison of one result transaction
    task automatic compare_status(input tick_status_t want);
        if (out_mode !== want.mode)
        begin
            $error("out_mode: expected %0d, got %0d", want.mode, out_mode);
            error_total++;
        end
        if (belt_on !== want.belt)
        begin
            $error("belt_on: expected %0d, got %0d", want.belt, belt_on);
            error_total++;
        end
        if (motor_on !== want.motor)
        begin
            $error("motor_on: expected %0d, got %0d", want.motor, motor_on);
            error_total++;
        end
        if (out_pills !== want.pills)
        begin
            $error("out_pills: expected %0d, got %0d", want.pills, out_pills);
            error_total++;
        end
        if (out_target !== want.target)
        begin
            $error("out_target: expected %0d, got %0d", want.target, out_target);
            error_total++;
        end
        if (out_total !== want.total)
        begin
            $error("out_total: expected %0d, got %0d", want.total, out_total);
            error_total++;
        end
        if (out_boxes !== want.boxes)
        begin
            $error("out_boxes: expected %0d, got %0d", want.boxes, out_boxes);
            error_total++;
        end
    endtask

    // Channel monitor: register access, results, then new ticks
    always @(posedge clk or negedge rst_n)
    begin : monitor
        tick_status_t next_status;
        if (!rst_n)
        begin
            cfg_debounce = DEBOUNCE_RESET;
            st_mode      = MODE_OFF;
            st_digits    = '0;
            st_tens      = '0;
            st_ones      = '0;
            st_target    = '0;
            st_pills     = '0;
            st_total     = '0;
            st_boxes     = '0;
            st_debounce  = '0;
            expected_status.delete();
            outstanding <= 0;
            mismatches  <= error_total;
        end
        else
        begin
            if (psel && penable && pready && paddr == ADDR_DEBOUNCE)
            begin
                if (pwrite)
                    cfg_debounce = pwdata[DEBOUNCE_W-1:0];
                else if (prdata[DEBOUNCE_W-1:0] !== cfg_debounce)
                begin
                    $error("debounce_ticks: expected %0d, got %0d", cfg_debounce,
                           prdata[DEBOUNCE_W-1:0]);
                    error_total++;
                end
            end

            if (out_valid && out_ready)
            begin
                if (expected_status.size() == 0)
                begin
                    $error("result transaction with no tick pending (out_mode %0d)", out_mode);
                    error_total++;
                end
                else
                    compare_status(expected_status.pop_front());
            end

            if (in_valid && in_ready)
            begin
                advance_sequencer(key_code, box_sensor, pill_pulse, next_status);
                expected_status.push_back(next_status);
            end

            outstanding <= expected_status.size();
            mismatches  <= error_total;
        end
    end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import pbcs_pkg::*;

    localparam logic [KEY_W-1:0] KEY_B    = 5'd11;
    localparam logic [KEY_W-1:0] KEY_D    = 5'd13;
    localparam logic [KEY_W-1:0] KEY_NONE = 5'd16;
    localparam logic [KEY_W-1:0] KEY_MAX  = 5'd31;

    localparam int PHASE_COUNT   = 7;
    localparam int SETTLE_CYCLES = 6;
    localparam int CYCLE_LIMIT   = 400000;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [31:0]        pwdata  = '0;
    logic [31:0]        prdata;
    logic               pready;

    logic               in_valid   = 1'b0;
    logic               in_ready;
    logic [KEY_W-1:0]   key_code   = KEY_NONE;
    logic               box_sensor = 1'b0;
    logic               pill_pulse = 1'b0;

    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [MODE_W-1:0]   out_mode;
    logic                belt_on;
    logic                motor_on;
    logic [PILLS_W-1:0]  out_pills;
    logic [TARGET_W-1:0] out_target;
    logic [TOTAL_W-1:0]  out_total;
    logic [BOXES_W-1:0]  out_boxes;

    int mismatches;
    int outstanding;
    int cycle_count  = 0;
    int ticks_sent   = 0;
    int debounce_now = int'(DEBOUNCE_RESET);
    bit burst        = 1'b0;

    pill_batch_counter_sequencer_unit uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .key_code   (key_code),
        .box_sensor (box_sensor),
        .pill_pulse (pill_pulse),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_mode   (out_mode),
        .belt_on    (belt_on),
        .motor_on   (motor_on),
        .out_pills  (out_pills),
        .out_target (out_target),
        .out_total  (out_total),
        .out_boxes  (out_boxes)
    );

    sequencer_check u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .key_code    (key_code),
        .box_sensor  (box_sensor),
        .pill_pulse  (pill_pulse),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_mode    (out_mode),
        .belt_on     (belt_on),
        .motor_on    (motor_on),
        .out_pills   (out_pills),
        .out_target  (out_target),
        .out_total   (out_total),
        .out_boxes   (out_boxes),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // 50 MHz clock
    always
    begin
        #10;
        clk = 1'b1;
        #10;
        clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 25);
    endfunction

    // Random level for a sensor or pulse input
    function automatic logic coin();
        return 1'($urandom_range(0, 1));
    endfunction

    // Key that moves no sequence forward: no key, unused codes, letters B-D, digits if with_digits
    function automatic logic [KEY_W-1:0] noise_key(input bit with_digits);
        logic [KEY_W-1:0] k;
        int               r;
        r = $urandom_range(0, 19);
        if (r < 11)
            k = KEY_NONE;
        else if (r < 16)
            k = KEY_W'($urandom_range(KEY_NONE + 1, KEY_MAX));
        else if (r < 18 || !with_digits)
            k = KEY_W'($urandom_range(KEY_B, KEY_D));
        else
            k = KEY_W'($urandom_range(0, KEY_DIGIT_MAX));
        return k;
    endfunction

    // One tick transaction; valid stays up across back-to-back ticks
    task automatic send_tick(input logic [KEY_W-1:0] k, input logic s, input logic p);
        int gap;
        gap = burst ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        key_code   <= k;
        box_sensor <= s;
        pill_pulse <= p;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        ticks_sent++;
    endtask

    task automatic send_noise(input bit with_digits);
        send_tick(noise_key(with_digits), coin(), coin());
    endtask

    // Stop offering ticks and let every result drain
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB transfer: setup cycle, access cycle, then the bus returns to idle
    task automatic apb_access(input bit wr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_DEBOUNCE;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // One bottling run: start, key in a target, then fill a few boxes
    task automatic run_batch();
        int  tens;
        int  ones;
        int  need;
        int  pulses;
        int  high_run;
        int  boxes_left;
        int  r;
        bit  aborted;
        logic p;
        burst = ($urandom_range(0, 3) == 0);

        repeat ($urandom_range(0, 2)) send_noise(1'b0);
        send_tick(KEY_A, coin(), coin());
        repeat ($urandom_range(0, 1)) send_noise(1'b0);
        send_tick(KEY_STAR, coin(), coin());

        // target entry, mostly single-digit targets
        r = $urandom_range(0, 19);
        tens = (r < 15) ? 0 : (r < 18) ? $urandom_range(1, 2) : $urandom_range(0, 9);
        ones = $urandom_range(0, 9);
        if ($urandom_range(0, 9) == 0)
        begin
            // third digit restarts the entry
            repeat (3) send_tick(KEY_W'($urandom_range(0, KEY_DIGIT_MAX)), 1'b0, 1'b0);
        end
        send_tick(KEY_W'(tens), coin(), coin());
        if ($urandom_range(0, 3) == 0)
            send_noise(1'b0);
        send_tick(KEY_W'(ones), coin(), coin());
        if ($urandom_range(0, 7) == 0)
        begin
            // stop and come back: digits kept for the start key
            send_tick(KEY_HASH, 1'b0, 1'b0);
            send_tick(KEY_STAR, 1'b0, 1'b0);
        end
        send_tick(KEY_STAR, 1'b0, coin());
        need = tens * 10 + ones;

        boxes_left = (debounce_now > 40) ? 1 : $urandom_range(1, 3);
        aborted = 1'b0;
        while (boxes_left > 0 && !aborted)
        begin
            // box arrives, sometimes with a sensor glitch first
            if ($urandom_range(0, 4) == 0)
            begin
                repeat ($urandom_range(1, 3)) send_tick(noise_key(1'b1), 1'b1, 1'b0);
                send_tick(noise_key(1'b1), 1'b0, coin());
            end
            if (debounce_now > 300)
                high_run = $urandom_range(5, 40);
            else
                high_run = debounce_now + $urandom_range(0, 2);
            if (high_run == 0)
                high_run = 1;
            repeat (high_run) send_tick(noise_key(1'b1), 1'b1, ($urandom_range(0, 7) == 0));

            // dispense until the box is full, with a rare abort
            pulses = 0;
            while (pulses <= need && !aborted)
            begin
                if ($urandom_range(0, 99) == 0)
                begin
                    send_tick(($urandom_range(0, 1) == 1) ? KEY_STAR : KEY_HASH,
                              coin(), 1'b0);
                    aborted = 1'b1;
                end
                else
                begin
                    p = ($urandom_range(0, 9) < 7);
                    send_tick(noise_key(1'b1), coin(), p);
                    if (p)
                        pulses++;
                end
            end
            boxes_left--;
        end

        send_tick(KEY_HASH, coin(), coin());
        if ($urandom_range(0, 2) != 0)
            send_tick(KEY_HASH, coin(), coin());
    endtask

    // Result side back-pressure, with a long hold-off now and then
    initial
    begin : receiver
        int hold;
        int run;
        int elapsed;
        int next_long;
        elapsed   = 0;
        next_long = 2500;
        @(posedge rst_n);
        forever
        begin
            if (elapsed >= next_long)
            begin
                hold      = 120;
                next_long = elapsed + 6000;
            end
            else
                hold = pick_gap();
            if (hold > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_ready <= 1'b1;
            run = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 150) : $urandom_range(1, 8);
            repeat (run) @(posedge clk);
            elapsed += hold + run;
        end
    end

    // Stimulus and verdict
    initial
    begin : stimulus
        int phase_debounce [PHASE_COUNT];
        int phase_ticks [PHASE_COUNT];
        int phase_end;
        phase_debounce = '{0, 1, 250, 65535, 3, 0, 2};
        phase_ticks    = '{320, 320, 280, 120, 300, 260, 250};
        phase_debounce[5] = $urandom_range(4, 12);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset value readback, then a short belt delay for the directed run
        apb_access(1'b0, '0);
        apb_access(1'b1, 2);
        apb_access(1'b0, '0);
        debounce_now = 2;

        // off: a digit, an unused code and hash ignored, A starts
        send_tick(5'd0, 1'b1, 1'b1);
        send_tick(KEY_MAX, 1'b0, 1'b0);
        send_tick(KEY_HASH, 1'b0, 1'b0);
        send_tick(KEY_A, 1'b1, 1'b1);
        // stopped: letter ignored, star enters setup
        send_tick(KEY_D, 1'b0, 1'b0);
        send_tick(KEY_STAR, 1'b0, 1'b0);
        // entry: letter ignored, 99, third digit dropped, then 00
        send_tick(KEY_B, 1'b0, 1'b0);
        send_tick(5'd9, 1'b0, 1'b0);
        send_tick(5'd9, 1'b0, 1'b0);
        send_tick(5'd5, 1'b0, 1'b0);
        send_tick(5'd0, 1'b0, 1'b0);
        send_tick(5'd0, 1'b0, 1'b0);
        // hash keeps the target, star re-enters, star starts with zero target
        send_tick(KEY_HASH, 1'b0, 1'b0);
        send_tick(KEY_STAR, 1'b0, 1'b0);
        send_tick(KEY_STAR, 1'b0, 1'b0);
        // belt: a low sensor restarts the debounce
        send_tick(KEY_NONE, 1'b1, 1'b0);
        send_tick(KEY_NONE, 1'b0, 1'b0);
        send_tick(KEY_NONE, 1'b1, 1'b0);
        send_tick(KEY_NONE, 1'b1, 1'b0);
        // zero target: box done with no pills
        send_tick(KEY_NONE, 1'b0, 1'b0);
        // star on the belt clears the target; new target 01
        send_tick(KEY_STAR, 1'b1, 1'b0);
        send_tick(5'd0, 1'b0, 1'b0);
        send_tick(5'd1, 1'b0, 1'b0);
        send_tick(KEY_STAR, 1'b0, 1'b0);
        send_tick(KEY_NONE, 1'b1, 1'b0);
        send_tick(KEY_NONE, 1'b1, 1'b0);
        send_tick(KEY_NONE, 1'b0, 1'b1);
        // abort while counting clears boxes, then back to off
        send_tick(KEY_NONE, 1'b1, 1'b0);
        send_tick(KEY_NONE, 1'b1, 1'b0);
        send_tick(KEY_HASH, 1'b0, 1'b0);
        send_tick(KEY_HASH, 1'b0, 1'b0);

        // random runs under several belt delays
        phase_end = ticks_sent;
        for (int i = 0; i < PHASE_COUNT; i++)
        begin
            wait_idle();
            apb_access(1'b1, phase_debounce[i]);
            apb_access(1'b0, '0);
            debounce_now = phase_debounce[i];
            phase_end += phase_ticks[i];
            while (ticks_sent < phase_end)
                run_batch();
        end

        wait_idle();
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
